[design/wmhp_pkg.sv]
// ----------------------------------------------------------------------------
// wmhp_pkg
// Shared types, codes and helpers for the 802.11 MAC header parser.
// ----------------------------------------------------------------------------
package wmhp_pkg;

  localparam int ADDR_W = 48;
  localparam int NUM_ADDR = 4;

  // frame type codes
  localparam logic [1:0] FT_MGMT = 2'd0;
  localparam logic [1:0] FT_CTRL = 2'd1;
  localparam logic [1:0] FT_DATA = 2'd2;
  localparam logic [1:0] FT_RSVD = 2'd3;

  // parse status codes
  localparam logic [1:0] ST_COMPLETE = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_RESERVED = 2'd2;

  // control subtypes that carry a second address, and the first subtype with an RA
  localparam logic [3:0] SUB_RTS = 4'd11;
  localparam logic [3:0] SUB_CFEND = 4'd14;
  localparam logic [3:0] SUB_CFEND_ACK = 4'd15;
  localparam logic [3:0] SUB_FIRST_RA = 4'd10;

  localparam logic [15:0] SNAP_MARK = 16'hAAAA;

  localparam logic [5:0] HDR_LEN_3ADDR = 6'd24;
  localparam logic [5:0] HDR_LEN_4ADDR = 6'd30;
  localparam logic [5:0] QOS_LEN = 6'd2;

  // captured header state
  typedef struct packed {
    logic [15:0]                       ctrl;
    logic [NUM_ADDR-1:0][ADDR_W-1:0]   addr;
    logic [15:0]                       seq;
    logic [15:0]                       qos;
    logic [63:0]                       head;
  } hdr_t;

  // one result word
  typedef struct packed {
    logic [1:0]        frame_type;
    logic [3:0]        frame_subtype;
    logic [7:0]        flag_bits;
    logic [1:0]        parse_status;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] bssid_addr;
    logic [ADDR_W-1:0] transmitter_addr;
    logic [15:0]       sequence_control;
    logic [15:0]       qos_control;
    logic [5:0]        header_length;
    logic [15:0]       payload_ethertype;
  } result_t;

  // offset of the QoS control word: after address 4 when toDS and fromDS
  function automatic logic [5:0] qos_offset(input logic [15:0] ctrl);
    return (ctrl[9:8] == 2'b11) ? HDR_LEN_4ADDR : HDR_LEN_3ADDR;
  endfunction

  // MAC header length of a data frame
  function automatic logic [5:0] hdr_length(input logic [15:0] ctrl);
    return qos_offset(ctrl) + (ctrl[7] ? QOS_LEN : 6'd0);
  endfunction

endpackage

[design/wmhp_decode.sv]
// ----------------------------------------------------------------------------
// wmhp_decode
// Maps a fully captured header and the frame length onto one result word.
// ----------------------------------------------------------------------------
module wmhp_decode (
  input  wmhp_pkg::hdr_t    hdr,
  input  logic [6:0]        frame_len,
  output wmhp_pkg::result_t res
);
  import wmhp_pkg::*;

  logic [1:0] ftype;
  logic [3:0] fsub;
  logic       two_addr;
  logic [5:0] hl;
  logic [6:0] hl_ext;
  logic [15:0] et_direct;
  logic [15:0] et_snap;

  assign ftype     = hdr.ctrl[3:2];
  assign fsub      = hdr.ctrl[7:4];
  assign two_addr  = (fsub == SUB_RTS) || (fsub == SUB_CFEND) || (fsub == SUB_CFEND_ACK);
  assign hl        = hdr_length(hdr.ctrl);
  assign hl_ext    = {1'b0, hl};
  assign et_direct = {hdr.head[7:0], hdr.head[15:8]};
  assign et_snap   = {hdr.head[55:48], hdr.head[63:56]};

  always_comb begin
    res = '0;
    if (frame_len < 7'd2) begin
      res.parse_status = ST_TRUNCATED;
    end else begin
      res.frame_type    = ftype;
      res.frame_subtype = fsub;
      res.flag_bits     = hdr.ctrl[15:8];
      unique case (ftype)
        FT_RSVD: begin
          res.parse_status = ST_RESERVED;
        end
        FT_MGMT: begin
          if (frame_len < 7'd24) begin
            res.parse_status = ST_TRUNCATED;
          end else begin
            res.dest_addr        = hdr.addr[0];
            res.src_addr         = hdr.addr[1];
            res.bssid_addr       = hdr.addr[2];
            res.sequence_control = hdr.seq;
          end
        end
        FT_CTRL: begin
          if (frame_len < 7'd10 || (two_addr && frame_len < 7'd16)) begin
            res.parse_status = ST_TRUNCATED;
          end else begin
            if (fsub >= SUB_FIRST_RA) res.dest_addr = hdr.addr[0];
            if (two_addr) res.src_addr = hdr.addr[1];
          end
        end
        default: begin
          if (frame_len < hl_ext) begin
            res.parse_status = ST_TRUNCATED;
          end else begin
            case (hdr.ctrl[9:8])
              2'b00: begin
                res.dest_addr  = hdr.addr[0];
                res.src_addr   = hdr.addr[1];
                res.bssid_addr = hdr.addr[2];
              end
              2'b01: begin
                res.dest_addr  = hdr.addr[2];
                res.src_addr   = hdr.addr[1];
                res.bssid_addr = hdr.addr[0];
              end
              2'b10: begin
                res.dest_addr  = hdr.addr[0];
                res.src_addr   = hdr.addr[2];
                res.bssid_addr = hdr.addr[1];
              end
              default: begin
                res.dest_addr        = hdr.addr[2];
                res.src_addr         = hdr.addr[3];
                res.bssid_addr       = hdr.addr[0];
                res.transmitter_addr = hdr.addr[1];
              end
            endcase
            res.sequence_control = hdr.seq;
            if (fsub[3]) res.qos_control = hdr.qos;
            res.header_length = hl;
            if (frame_len >= hl_ext + 7'd2) begin
              if (et_direct != SNAP_MARK) begin
                res.payload_ethertype = et_direct;
              end else if (frame_len >= hl_ext + 7'd8) begin
                res.payload_ethertype = et_snap;
              end
            end
          end
        end
      endcase
    end
  end

endmodule

[design/wifi_mac_header_parser.sv]
// ----------------------------------------------------------------------------
// wifi_mac_header_parser
// 802.11 MAC header parser: one frame byte per word in, one result per frame.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one frame byte per word, with in_end_of_frame
//   high on the final byte. Each byte is captured into the header registers
//   in the cycle it is accepted, so one byte is taken every clock cycle
//   while in_stall is low. On the final byte the header is decoded and one
//   result word is loaded into the output register; it is presented on out_*
//   in the cycle after the final byte was accepted. Non-final bytes produce
//   no output. Throughput is one byte per cycle while in_stall is low,
//   frames may follow back to back; the capture state clears itself after
//   every final byte. The output register parts the two sides: while a
//   result waits, bytes keep being taken. Only when the result is held by
//   out_stall is in_stall raised, so no byte is taken until the result drains.
//   A synchronous low rst_n empties the output register and clears the
//   byte position and all captured header fields.
// ----------------------------------------------------------------------------
module wifi_mac_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_type,
  output logic [3:0]  out_frame_subtype,
  output logic [7:0]  out_flag_bits,
  output logic [1:0]  out_parse_status,
  output logic [47:0] out_dest_addr,
  output logic [47:0] out_src_addr,
  output logic [47:0] out_bssid_addr,
  output logic [47:0] out_transmitter_addr,
  output logic [15:0] out_sequence_control,
  output logic [15:0] out_qos_control,
  output logic [5:0]  out_header_length,
  output logic [15:0] out_payload_ethertype
);
  import wmhp_pkg::*;

  logic       in_accept;
  logic       frame_done;
  logic [5:0] pos_r;
  logic [5:0] pos_nxt;
  hdr_t       hdr_r;
  hdr_t       hdr_nxt;
  hdr_t       hdr_cap;      // header state with the current byte merged in
  logic [6:0] frame_len;
  result_t    res;
  result_t    res_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [5:0] qoff;
  logic [5:0] hl;
  logic [5:0] p;
  logic [5:0] rel;

  // Hold the input only while a finished result is being stalled.
  assign in_stall   = out_valid_r & out_stall;
  assign in_accept  = in_valid & ~in_stall;
  assign frame_done = in_accept & in_end_of_frame;

  assign p         = pos_r;
  assign frame_len = {1'b0, pos_r} + 7'd1;
  assign qoff      = qos_offset(hdr_r.ctrl);
  assign hl        = hdr_length(hdr_r.ctrl);

  // Merge the incoming byte into the header field that owns its position.
  // Every slot is written at most once per frame and starts at zero.
  always_comb begin
    hdr_cap = hdr_r;
    rel     = '0;
    if (p < 6'd2) begin
      hdr_cap.ctrl[8*p[0] +: 8] = in_data_byte;
    end else if (p >= 6'd4 && p < 6'd10) begin
      rel = p - 6'd4;
      hdr_cap.addr[0][8*rel[2:0] +: 8] = in_data_byte;
    end else if (p >= 6'd10 && p < 6'd16) begin
      rel = p - 6'd10;
      hdr_cap.addr[1][8*rel[2:0] +: 8] = in_data_byte;
    end else if (p >= 6'd16 && p < 6'd22) begin
      rel = p - 6'd16;
      hdr_cap.addr[2][8*rel[2:0] +: 8] = in_data_byte;
    end else if (p >= 6'd22 && p < 6'd24) begin
      hdr_cap.seq[8*p[0] +: 8] = in_data_byte;
    end else if (p >= 6'd24 && p < 6'd30) begin
      rel = p - 6'd24;
      hdr_cap.addr[3][8*rel[2:0] +: 8] = in_data_byte;
    end
    // QoS word sits right after sequence control, or after address 4 when present
    if (p >= 6'd2 && (p == qoff || p == qoff + 6'd1)) begin
      hdr_cap.qos[8*(p[0] ^ qoff[0]) +: 8] = in_data_byte;
    end
    // first eight payload bytes, for the ethertype
    if (p >= 6'd2 && p >= hl && p < hl + 6'd8) begin
      rel = p - hl;
      hdr_cap.head[8*rel[2:0] +: 8] = in_data_byte;
    end
  end

  wmhp_decode u_decode (
    .hdr       (hdr_cap),
    .frame_len (frame_len),
    .res       (res)
  );

  // Advance the position (saturating), drop all state after the final byte.
  always_comb begin
    pos_nxt = pos_r;
    hdr_nxt = hdr_r;
    if (frame_done) begin
      pos_nxt = '0;
      hdr_nxt = '0;
    end else if (in_accept) begin
      pos_nxt = (pos_r == 6'd63) ? pos_r : pos_r + 6'd1;
      hdr_nxt = hdr_cap;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (frame_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      hdr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      hdr_r       <= hdr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: load on the final byte only.
  always_ff @(posedge clk) begin
    if (frame_done) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_frame_type        = res_r.frame_type;
  assign out_frame_subtype     = res_r.frame_subtype;
  assign out_flag_bits         = res_r.flag_bits;
  assign out_parse_status      = res_r.parse_status;
  assign out_dest_addr         = res_r.dest_addr;
  assign out_src_addr          = res_r.src_addr;
  assign out_bssid_addr        = res_r.bssid_addr;
  assign out_transmitter_addr  = res_r.transmitter_addr;
  assign out_sequence_control  = res_r.sequence_control;
  assign out_qos_control       = res_r.qos_control;
  assign out_header_length     = res_r.header_length;
  assign out_payload_ethertype = res_r.payload_ethertype;

endmodule

[tb/sv/wifi_mac_header_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wifi_mac_header_parser_tb
// Self-checking bench for the 802.11 MAC header parser.
// A few hand-picked frames come first, then random frames of every type, of
// full, short and overlong size. Every accepted byte feeds a header tracker
// that predicts the one result of each frame. Results are checked in order,
// field by field. Both sides idle at random, and the receiver stalls once for
// a long stretch.
// ----------------------------------------------------------------------------
module wifi_mac_header_parser_tb;
  import wmhp_pkg::*;

  localparam int IDLE_PCT      = 19;
  localparam int BYTE_TARGET   = 1050;
  localparam int CTRL_MIN_LEN  = 10;   // control frame with one address
  localparam int CTRL_TWO_LEN  = 16;   // control frame with two addresses
  localparam int FULL_POS      = 63;   // byte position saturates here
  localparam int HOLD_AT       = 10;   // result count that starts the long stall
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_FROM    = 600;  // cycle window with no idling at all
  localparam int QUIET_TO      = 1000;
  localparam int DRAIN_CYCLES  = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } byte_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_frame = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_frame_type;
  logic [3:0]  out_frame_subtype;
  logic [7:0]  out_flag_bits;
  logic [1:0]  out_parse_status;
  logic [47:0] out_dest_addr;
  logic [47:0] out_src_addr;
  logic [47:0] out_bssid_addr;
  logic [47:0] out_transmitter_addr;
  logic [15:0] out_sequence_control;
  logic [15:0] out_qos_control;
  logic [5:0]  out_header_length;
  logic [15:0] out_payload_ethertype;

  // bytes waiting to go out, and parse results owed by the block
  byte_word_t frame_bytes_q[$];
  result_t    parse_results_q[$];

  // header tracker: mirrors the capture registers of the block
  int          trk_pos;
  logic [15:0] trk_fc;
  logic [47:0] trk_addr[NUM_ADDR];
  logic [15:0] trk_seq;
  logic [15:0] trk_qos;
  logic [63:0] trk_head;

  int         fail_cnt = 0;
  int         results_seen = 0;
  int         cyc = 0;
  int         hold_left = 0;
  bit         held = 1'b0;
  byte_word_t drv_word;
  result_t    want;

  wifi_mac_header_parser u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_end_of_frame      (in_end_of_frame),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_frame_type       (out_frame_type),
    .out_frame_subtype    (out_frame_subtype),
    .out_flag_bits        (out_flag_bits),
    .out_parse_status     (out_parse_status),
    .out_dest_addr        (out_dest_addr),
    .out_src_addr         (out_src_addr),
    .out_bssid_addr       (out_bssid_addr),
    .out_transmitter_addr (out_transmitter_addr),
    .out_sequence_control (out_sequence_control),
    .out_qos_control      (out_qos_control),
    .out_header_length    (out_header_length),
    .out_payload_ethertype(out_payload_ethertype)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // MAC header length of a data frame: four addresses when toDS and fromDS
  // are both set, two more bytes for the QoS subtypes
  function automatic int mac_hdr_bytes(input logic [15:0] fc);
    return ((fc[9:8] == 2'b11) ? int'(HDR_LEN_4ADDR) : int'(HDR_LEN_3ADDR)) +
           (fc[7] ? int'(QOS_LEN) : 0);
  endfunction

  function automatic bit ctrl_two_addr(input logic [3:0] sub);
    return (sub == SUB_RTS) || (sub == SUB_CFEND) || (sub == SUB_CFEND_ACK);
  endfunction

  // Idle roll shared by both sides; never idle inside the quiet window.
  function automatic bit roll_idle();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  task automatic clear_tracker();
    trk_pos = 0;
    trk_fc = '0;
    foreach (trk_addr[i]) trk_addr[i] = '0;
    trk_seq = '0;
    trk_qos = '0;
    trk_head = '0;
  endtask

  // Advance the tracker by one accepted byte; on the final byte, build the
  // expected result and queue it.
  task automatic take_byte(input logic [7:0] b, input logic eof);
    int          p;
    int          len;
    int          qoff;
    int          hl;
    logic [1:0]  ftype;
    logic [3:0]  sub;
    logic [1:0]  st;
    logic [15:0] et;
    bit          two;
    result_t     r;

    p = trk_pos;
    if (p < 2) begin
      trk_fc = trk_fc | (16'(b) << (8 * p));
    end else begin
      // bytes 4..21 fill addresses 1-3, 22..23 sequence control,
      // 24..29 address 4 (present or not)
      if (p >= 4 && p < 30) begin
        if (p >= 22 && p < 24)
          trk_seq = trk_seq | (16'(b) << (8 * (p - 22)));
        else if (p >= 24)
          trk_addr[3] = trk_addr[3] | (48'(b) << (8 * (p - 24)));
        else
          trk_addr[(p - 4) / 6] = trk_addr[(p - 4) / 6] | (48'(b) << (8 * ((p - 4) % 6)));
      end
      // QoS control follows sequence control, or address 4 when present
      qoff = (trk_fc[9:8] == 2'b11) ? int'(HDR_LEN_4ADDR) : int'(HDR_LEN_3ADDR);
      if (p >= qoff && p < qoff + 2)
        trk_qos = trk_qos | (16'(b) << (8 * (p - qoff)));
      hl = mac_hdr_bytes(trk_fc);
      if (p >= hl && p < hl + 8)
        trk_head = trk_head | (64'(b) << (8 * (p - hl)));
    end
    if (trk_pos < FULL_POS) trk_pos++;
    if (!eof) return;

    len = p + 1;
    r = '0;
    st = ST_COMPLETE;
    ftype = trk_fc[3:2];
    sub = trk_fc[7:4];
    if (len < 2) begin
      // frame control itself is cut short: nothing else is reported
      st = ST_TRUNCATED;
    end else begin
      r.frame_type = ftype;
      r.frame_subtype = sub;
      r.flag_bits = trk_fc[15:8];
      case (ftype)
        FT_RSVD: st = ST_RESERVED;
        FT_MGMT: begin
          if (len < int'(HDR_LEN_3ADDR)) st = ST_TRUNCATED;
          else begin
            r.dest_addr = trk_addr[0];
            r.src_addr = trk_addr[1];
            r.bssid_addr = trk_addr[2];
            r.sequence_control = trk_seq;
          end
        end
        FT_CTRL: begin
          two = ctrl_two_addr(sub);
          if (len < CTRL_MIN_LEN || (two && len < CTRL_TWO_LEN)) st = ST_TRUNCATED;
          else begin
            if (sub >= SUB_FIRST_RA) r.dest_addr = trk_addr[0];
            if (two) r.src_addr = trk_addr[1];
          end
        end
        default: begin
          hl = mac_hdr_bytes(trk_fc);
          if (len < int'(HDR_LEN_3ADDR) || len < hl) st = ST_TRUNCATED;
          else begin
            // address roles follow toDS/fromDS
            case (trk_fc[9:8])
              2'b00: begin
                r.dest_addr = trk_addr[0];
                r.src_addr = trk_addr[1];
                r.bssid_addr = trk_addr[2];
              end
              2'b01: begin
                r.dest_addr = trk_addr[2];
                r.src_addr = trk_addr[1];
                r.bssid_addr = trk_addr[0];
              end
              2'b10: begin
                r.dest_addr = trk_addr[0];
                r.src_addr = trk_addr[2];
                r.bssid_addr = trk_addr[1];
              end
              default: begin
                r.dest_addr = trk_addr[2];
                r.src_addr = trk_addr[3];
                r.bssid_addr = trk_addr[0];
                r.transmitter_addr = trk_addr[1];
              end
            endcase
            r.sequence_control = trk_seq;
            if (sub[3]) r.qos_control = trk_qos;
            r.header_length = 6'(hl);
            // ethertype is big-endian; behind an LLC/SNAP mark it sits at
            // payload bytes six and seven
            if (len >= hl + 2) begin
              et = {trk_head[7:0], trk_head[15:8]};
              if (et == SNAP_MARK)
                et = (len >= hl + 8) ? {trk_head[55:48], trk_head[63:56]} : 16'h0000;
              r.payload_ethertype = et;
            end
          end
        end
      endcase
    end
    r.parse_status = st;
    parse_results_q.push_back(r);
    clear_tracker();
  endtask

  // Queue one frame: frame control bytes given, the rest random. With snap
  // set, a data frame long enough gets the LLC/SNAP mark after its header.
  task automatic add_frame(input logic [7:0] fc0, input logic [7:0] fc1,
                           input int len, input bit snap);
    logic [7:0] fb[$];
    int         hl;

    hl = mac_hdr_bytes({fc1, fc0});
    for (int i = 0; i < len; i++)
      fb.push_back((i == 0) ? fc0 : (i == 1) ? fc1 : 8'($urandom));
    if (snap && fc0[3:2] == FT_DATA && len > hl + 1) begin
      fb[hl] = SNAP_MARK[7:0];
      fb[hl + 1] = SNAP_MARK[15:8];
    end
    foreach (fb[i]) frame_bytes_q.push_back('{data: fb[i], eof: (i == len - 1)});
  endtask

  task automatic add_random_frame();
    logic [7:0] fc0;
    logic [7:0] fc1;
    int         pick;
    int         full;
    int         len;

    fc0 = 8'($urandom);
    fc1 = 8'($urandom);
    pick = $urandom_range(0, 99);
    fc0[3:2] = (pick < 50) ? FT_DATA : (pick < 72) ? FT_CTRL : (pick < 92) ? FT_MGMT : FT_RSVD;
    case (fc0[3:2])
      FT_DATA: full = mac_hdr_bytes({fc1, fc0});
      FT_CTRL: full = ctrl_two_addr(fc0[7:4]) ? CTRL_TWO_LEN : CTRL_MIN_LEN;
      FT_MGMT: full = HDR_LEN_3ADDR;
      default: full = 8;
    endcase
    // mostly whole headers with a short body; some cut short, some right at
    // the edge, a few past the point where the byte position saturates
    pick = $urandom_range(0, 99);
    if (pick < 72) len = full + $urandom_range(0, 10);
    else if (pick < 87) len = $urandom_range(1, full - 1);
    else if (pick < 94) len = full;
    else len = $urandom_range(65, 72);
    add_frame(fc0, fc1, len, $urandom_range(0, 2) == 0);
  endtask

  // Driver: hold the word until taken, then advance to the next queued byte.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'h00;
      in_end_of_frame <= 1'b0;
      clear_tracker();
    end else begin
      if (in_valid && !in_stall) take_byte(in_data_byte, in_end_of_frame);
      if (!in_valid || !in_stall) begin
        if (frame_bytes_q.size() != 0 && !roll_idle()) begin
          drv_word = frame_bytes_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= drv_word.data;
          in_end_of_frame <= drv_word.eof;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(input string name, input logic [47:0] exp_v,
                           input logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // Monitor: check each taken result against the oldest prediction, and
  // drive out_stall with random idling plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      cyc++;
      if (out_valid && !out_stall) begin
        if (parse_results_q.size() == 0) begin
          $error("result with no frame pending: type %h status %h",
                 out_frame_type, out_parse_status);
          fail_cnt++;
        end else begin
          want = parse_results_q.pop_front();
          cmp_field("frame_type", 48'(want.frame_type), 48'(out_frame_type));
          cmp_field("frame_subtype", 48'(want.frame_subtype), 48'(out_frame_subtype));
          cmp_field("flag_bits", 48'(want.flag_bits), 48'(out_flag_bits));
          cmp_field("parse_status", 48'(want.parse_status), 48'(out_parse_status));
          cmp_field("dest_addr", want.dest_addr, out_dest_addr);
          cmp_field("src_addr", want.src_addr, out_src_addr);
          cmp_field("bssid_addr", want.bssid_addr, out_bssid_addr);
          cmp_field("transmitter_addr", want.transmitter_addr, out_transmitter_addr);
          cmp_field("sequence_control", 48'(want.sequence_control),
                    48'(out_sequence_control));
          cmp_field("qos_control", 48'(want.qos_control), 48'(out_qos_control));
          cmp_field("header_length", 48'(want.header_length), 48'(out_header_length));
          cmp_field("payload_ethertype", 48'(want.payload_ethertype),
                    48'(out_payload_ethertype));
        end
        results_seen++;
      end
      // long hold-off: the next result parks in the output register and the
      // block has to stall its byte input until we let go
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (results_seen >= HOLD_AT && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= roll_idle();
      end
    end
  end

  initial begin
    // directed: one-byte frames of all zeros and all ones, a reserved type,
    // a complete ACK, a data frame cut off after frame control
    add_frame(8'h00, 8'h00, 1, 1'b0);
    add_frame(8'hFF, 8'h00, 1, 1'b0);
    add_frame(8'hFE, 8'h00, 2, 1'b0);
    add_frame(8'hD4, 8'h10, CTRL_MIN_LEN, 1'b0);
    add_frame(8'h88, 8'h03, 2, 1'b0);
    while (frame_bytes_q.size() < BYTE_TARGET) add_random_frame();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // drain: every byte sent and every predicted result seen
    while (frame_bytes_q.size() != 0 || in_valid || parse_results_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
design/wmhp_pkg.sv
design/wmhp_decode.sv
design/wifi_mac_header_parser.sv
tb/sv/wifi_mac_header_parser_tb.sv
